/* rtl/core/dwhs_pkg.sv */
`timescale 1ns / 1ps

package dwhs_pkg;

   // Fixed widths of the datapath
   localparam int VALUE_W     = 64;
   localparam int HALF_W      = 32;
   localparam int BIT_CNT_W   = $clog2(VALUE_W);

   // Defaults for the top level parameters
   localparam int MAX_DIGITS_DEF = 64;
   localparam int BASE_WIDTH_DEF = 16;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DIGIT,
      ST_READ,
      ST_MLO,
      ST_MHI,
      ST_ACC,
      ST_WLO,
      ST_WHI,
      ST_DONE
   } state_type;

   // Operand pairs of the shared 32 by 32 multiplier
   typedef enum logic [1:0] {
      MUL_WL_DIGIT,
      MUL_WH_DIGIT,
      MUL_WL_BASE,
      MUL_WH_BASE
   } mul_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic        load;
      logic        div_start;
      logic        div_step;
      logic        digit_wr;
      logic        rd;
      logic        count_reach;
      mul_sel_type mul_sel;
      logic        sum_lo;
      logic        sum_hi;
      logic        wgt_lo;
      logic        wgt_hi;
      logic        publish;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic q_zero;
      logic full;
      logic ndig_zero;
      logic div_last;
      logic hit;
      logic last_digit;
   } status_type;

endpackage

/* rtl/core/dwhs_ctrl.sv */
`timescale 1ns / 1ps

module dwhs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dwhs_pkg::status_type sts,
   output dwhs_pkg::cmd_type    cmd
);
   import dwhs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_WL_DIGIT;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.q_zero || sts.full) begin
               state_in = sts.ndig_zero ? ST_DONE : ST_READ;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            cmd.digit_wr = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_MLO;
         end
         ST_MLO: begin
            cmd.mul_sel     = MUL_WL_DIGIT;
            cmd.count_reach = 1'b1;
            state_in        = ST_MHI;
         end
         ST_MHI: begin
            cmd.mul_sel = MUL_WH_DIGIT;
            cmd.sum_lo  = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.sum_hi  = 1'b1;
            cmd.mul_sel = MUL_WL_BASE;
            state_in    = (sts.hit || sts.last_digit) ? ST_DONE : ST_WLO;
         end
         ST_WLO: begin
            cmd.mul_sel = MUL_WH_BASE;
            cmd.wgt_lo  = 1'b1;
            state_in    = ST_WHI;
         end
         ST_WHI: begin
            cmd.wgt_hi = 1'b1;
            state_in   = ST_READ;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until taken, load a new one on publish
   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   // A new result never overwrites one still waiting
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result published over a waiting item");

endmodule

/* rtl/core/dwhs_dpath.sv */
`timescale 1ns / 1ps

module dwhs_dpath #(
   parameter int MAX_DIGITS = dwhs_pkg::MAX_DIGITS_DEF,
   parameter int BASE_WIDTH = dwhs_pkg::BASE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [BASE_WIDTH-1:0]         csr_wdata,
   input  logic [dwhs_pkg::VALUE_W-1:0]  req_value,
   output logic [dwhs_pkg::VALUE_W-1:0]  rsp_low_part,
   input  dwhs_pkg::cmd_type             cmd,
   output dwhs_pkg::status_type          sts
);
   import dwhs_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   // Configuration and working registers
   logic [BASE_WIDTH-1:0] cfg_base_ff;
   logic [BASE_WIDTH-1:0] base_ff, base_in;
   logic [VALUE_W-1:0]    q_ff, q_in;
   logic [BASE_WIDTH-1:0] rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]  bit_ff;
   logic [CNT_W-1:0]      ndig_ff;
   logic [CNT_W-1:0]      nz_cnt_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      reached_ff;
   logic [BASE_WIDTH-1:0] rd_ff;
   logic [VALUE_W-1:0]    weight_ff;
   logic [VALUE_W-1:0]    sum_ff;
   logic [VALUE_W-1:0]    mul_ff;
   logic [VALUE_W-1:0]    out_ff;

   logic [BASE_WIDTH-1:0] digit_mem [MAX_DIGITS];

   // Divider step signals
   logic [BASE_WIDTH:0]   shift_w;
   logic [BASE_WIDTH:0]   diff_w;
   logic                  ge;

   // Multiplier operands
   logic [HALF_W-1:0]     op_a;
   logic [HALF_W-1:0]     op_b;
   logic [CNT_W-1:0]      target;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_ff <= BASE_WIDTH'(2);
      end else if (csr_we) begin
         cfg_base_ff <= csr_wdata;
      end
   end

   // Saturate a base below two
   assign base_in = (cfg_base_ff < BASE_WIDTH'(2)) ? BASE_WIDTH'(2) : cfg_base_ff;

   // One restoring division step: a quotient bit per cycle
   assign shift_w = {rem_ff, q_ff[VALUE_W-1]};
   assign diff_w  = shift_w - {1'b0, base_ff};
   assign ge      = shift_w >= {1'b0, base_ff};
   assign rem_in  = ge ? diff_w[BASE_WIDTH-1:0] : shift_w[BASE_WIDTH-1:0];
   assign q_in    = {q_ff[VALUE_W-2:0], ge};

   // Conversion registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_WIDTH'(2);
         q_ff      <= '0;
         rem_ff    <= '0;
         bit_ff    <= '0;
         ndig_ff   <= '0;
         nz_cnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            base_ff   <= base_in;
            q_ff      <= req_value;
            rem_ff    <= '0;
            ndig_ff   <= '0;
            nz_cnt_ff <= '0;
         end
         if (cmd.div_start) begin
            rem_ff <= '0;
            bit_ff <= '0;
         end
         if (cmd.div_step) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            bit_ff <= bit_ff + BIT_CNT_W'(1);
         end
         if (cmd.digit_wr) begin
            ndig_ff <= ndig_ff + CNT_W'(1);
            if (rem_ff != '0) nz_cnt_ff <= nz_cnt_ff + CNT_W'(1);
         end
      end
   end

   // Digit store, registered read
   always_ff @(posedge clock) begin
      if (cmd.digit_wr) digit_mem[ndig_ff[IDX_W-1:0]] <= rem_ff;
      if (cmd.rd) rd_ff <= digit_mem[idx_ff[IDX_W-1:0]];
   end

   // Shared multiplier, registered
   always_comb begin
      case (cmd.mul_sel)
         MUL_WL_DIGIT: begin
            op_a = weight_ff[HALF_W-1:0];
            op_b = HALF_W'(rd_ff);
         end
         MUL_WH_DIGIT: begin
            op_a = weight_ff[VALUE_W-1:HALF_W];
            op_b = HALF_W'(rd_ff);
         end
         MUL_WL_BASE: begin
            op_a = weight_ff[HALF_W-1:0];
            op_b = HALF_W'(base_ff);
         end
         MUL_WH_BASE: begin
            op_a = weight_ff[VALUE_W-1:HALF_W];
            op_b = HALF_W'(base_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= VALUE_W'(op_a) * VALUE_W'(op_b);
   end

   // Scan registers: weight, partial sum, running count
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= VALUE_W'(1);
         sum_ff     <= '0;
         idx_ff     <= '0;
         reached_ff <= '0;
      end else begin
         if (cmd.load) begin
            weight_ff  <= VALUE_W'(1);
            sum_ff     <= '0;
            idx_ff     <= '0;
            reached_ff <= '0;
         end
         if (cmd.count_reach && rd_ff != '0) reached_ff <= reached_ff + CNT_W'(1);
         if (cmd.sum_lo) sum_ff <= sum_ff + mul_ff;
         if (cmd.sum_hi) sum_ff <= sum_ff + {mul_ff[HALF_W-1:0], {HALF_W{1'b0}}};
         if (cmd.wgt_lo) weight_ff <= mul_ff;
         if (cmd.wgt_hi) begin
            weight_ff <= weight_ff + {mul_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            idx_ff    <= idx_ff + CNT_W'(1);
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.publish) out_ff <= sum_ff;
   end

   assign rsp_low_part = out_ff;

   // Status back to the controller
   assign target         = nz_cnt_ff >> 1;
   assign sts.q_zero     = (q_ff == '0);
   assign sts.full       = (ndig_ff == CNT_W'(MAX_DIGITS));
   assign sts.ndig_zero  = (ndig_ff == '0);
   assign sts.div_last   = (bit_ff == {BIT_CNT_W{1'b1}});
   assign sts.hit        = (reached_ff >= target);
   assign sts.last_digit = ((idx_ff + CNT_W'(1)) == ndig_ff);

   // Remainder always stays below the base
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff < base_ff)
      else $error("remainder not below base");

   // No digit is written past the store
   a_digit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.digit_wr |-> (ndig_ff < CNT_W'(MAX_DIGITS)))
      else $error("digit store overrun");

   // Reading a digit only within those produced
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> (idx_ff < ndig_ff))
      else $error("digit read beyond count");

endmodule

/* rtl/core/digit_weight_half_split.sv */
`timescale 1ns / 1ps

// Half-weight digit split.
// Each item on the req_ channel carries a 64-bit value. The block writes it
// in the base held in the csr_ register (values 0 and 1 act as 2), counts the
// nonzero digits, and returns on the rsp_ channel the sum of digit times
// weight from the lowest digit up to the one where the running nonzero count
// reaches half the total (lowest digit alone when that half is zero).
// One item is in work at a time. Each digit passes through the bit-serial
// divider (64 quotient steps, a store write and a check); the weighted sum
// then reads each digit used, multiplies it by the weight in two halves and
// adds both products, then (but for the last digit) multiplies the weight by
// the base, through one 32 by 32 multiplier shared by the digit and weight
// products. The result sits in an output register: the next item is taken
// while it waits, and a finished item holds in the controller until the
// receiver has taken the previous one.
// Reset (synchronous) empties the block, sets the base to 2 and drops any
// waiting result. The user must write the base only while the block is
// idle; the block itself does not enforce this.
module digit_weight_half_split #(
   parameter int MAX_DIGITS = dwhs_pkg::MAX_DIGITS_DEF,
   parameter int BASE_WIDTH = dwhs_pkg::BASE_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [BASE_WIDTH-1:0]        csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dwhs_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dwhs_pkg::VALUE_W-1:0] rsp_low_part
);
   import dwhs_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // Sequencer
   dwhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Divider, digit store, multiplier and accumulators
   dwhs_dpath #(
      .MAX_DIGITS (MAX_DIGITS),
      .BASE_WIDTH (BASE_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_value    (req_value),
      .rsp_low_part (rsp_low_part),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule
